FILE: hdl/lac_pkg.sv
`timescale 1ns / 1ps

package lac_pkg;

  // Item kinds on the input channel.
  typedef enum logic [1:0] {
    FUNC_DATAGRAM = 2'd0,
    FUNC_RESULT   = 2'd1,
    FUNC_TICK     = 2'd2
  } lac_func_e;

  // Link phase; the fourth code is unreachable and behaves as idle.
  typedef enum logic [1:0] {
    PHASE_IDLE      = 2'd0,
    PHASE_ATTACHING = 2'd1,
    PHASE_RELEASING = 2'd2
  } lac_phase_e;

  localparam logic [1:0] REPLY_ATTACHED = 2'd0;
  localparam logic [1:0] REPLY_DENIED   = 2'd1;
  localparam logic [1:0] REPLY_RELEASED = 2'd2;

  localparam logic [2:0] CFG_DCC_ADDRESS  = 3'd0;
  localparam logic [2:0] CFG_KEEPALIVE_MS = 3'd1;
  localparam logic [2:0] CFG_MOTIVE_CLASS = 3'd2;
  localparam logic [2:0] CFG_ATTACH       = 3'd3;
  localparam logic [2:0] CFG_RELEASE      = 3'd4;
  localparam logic [2:0] CFG_SET_SPEED    = 3'd5;
  localparam logic [2:0] CFG_SET_FUNCTION = 3'd6;

  localparam logic [15:0] KEEPALIVE_RESET = 16'd5000;
  localparam logic [7:0]  ATTACH_RESET    = 8'd1;
  localparam logic [7:0]  RELEASE_RESET   = 8'd2;
  localparam logic [7:0]  SET_SPEED_RESET = 8'd3;
  localparam logic [7:0]  SET_FUNC_RESET  = 8'd4;

  localparam logic [6:0]  SPEED_MAX     = 7'd127;
  // 5243 / 2^19 approximates 1/100 exactly for dividends below 43690.
  localparam logic [12:0] RECIP_100     = 13'd5243;
  localparam int          RECIP_SHIFT   = 19;
  localparam logic [7:0]  FUNC_NUM_MAX  = 8'd32;

  typedef struct packed {
    logic [1:0]  func;
    logic [47:0] source_node;
    logic [7:0]  class_byte;
    logic [7:0]  command_byte;
    logic [7:0]  arg_a;
    logic [7:0]  arg_b;
    logic        accepted;
    logic [15:0] now_ms;
  } lac_in_t;

  typedef struct packed {
    logic               handled;
    logic               reply_valid;
    logic [1:0]         reply_kind;
    logic [47:0]        reply_dest;
    logic               speed_cmd_valid;
    logic               speed_cmd_basic;
    logic signed [7:0]  signed_speed;
    logic               function_cmd_valid;
    logic [31:0]        function_mask;
    logic               detached;
  } lac_out_t;

  typedef struct packed {
    logic [2:0]  addr;
    logic [15:0] wdata;
  } lac_cfg_t;

  typedef struct packed {
    logic [15:0] dcc_address;
    logic [15:0] keepalive_ms;
    logic [7:0]  motive_class_code;
    logic [7:0]  attach_code;
    logic [7:0]  release_code;
    logic [7:0]  set_speed_code;
    logic [7:0]  set_function_code;
  } lac_regs_t;

  // Speed step with direction applied, as an 8-bit two's complement value.
  function automatic logic signed [7:0] lac_signed_speed(input logic [6:0] step,
                                                         input logic       rev);
    logic [7:0] mag;
    mag = {1'b0, step};
    return rev ? $signed(8'd0 - mag) : $signed(mag);
  endfunction

endpackage

FILE: hdl/lac_stream_if.sv
`timescale 1ns / 1ps

interface lac_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/lac_cfg_regs.sv
`timescale 1ns / 1ps

module lac_cfg_regs
  import lac_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_en_i,
  input  lac_cfg_t  wr_i,
  output lac_regs_t regs_o
);

  lac_regs_t regs_q, regs_d;

  always_comb begin
    regs_d = regs_q;
    if (wr_en_i) begin
      case (wr_i.addr)
        CFG_DCC_ADDRESS:  regs_d.dcc_address       = wr_i.wdata;
        CFG_KEEPALIVE_MS: regs_d.keepalive_ms      = wr_i.wdata;
        CFG_MOTIVE_CLASS: regs_d.motive_class_code = wr_i.wdata[7:0];
        CFG_ATTACH:       regs_d.attach_code       = wr_i.wdata[7:0];
        CFG_RELEASE:      regs_d.release_code      = wr_i.wdata[7:0];
        CFG_SET_SPEED:    regs_d.set_speed_code    = wr_i.wdata[7:0];
        CFG_SET_FUNCTION: regs_d.set_function_code = wr_i.wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.dcc_address       <= '0;
      regs_q.keepalive_ms      <= KEEPALIVE_RESET;
      regs_q.motive_class_code <= '0;
      regs_q.attach_code       <= ATTACH_RESET;
      regs_q.release_code      <= RELEASE_RESET;
      regs_q.set_speed_code    <= SET_SPEED_RESET;
      regs_q.set_function_code <= SET_FUNC_RESET;
    end else begin
      regs_q <= regs_d;
    end
  end

  assign regs_o = regs_q;

endmodule

FILE: hdl/lac_core.sv
`timescale 1ns / 1ps

module lac_core
  import lac_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      advance_i,
  input  lac_in_t   item_i,
  input  lac_regs_t regs_i,
  output lac_out_t  result_o
);

  logic        is_free_q, is_free_d;
  logic [47:0] owner_q, owner_d;
  lac_phase_e  phase_q, phase_d;
  logic [6:0]  step_q, step_d;
  logic        rev_q, rev_d;
  logic [31:0] fbits_q, fbits_d;
  logic [15:0] last_send_q, last_send_d;

  logic        src_is_owner;
  logic        owned_by_src;
  logic [14:0] pct_x126;
  logic [27:0] prod;
  logic [9:0]  step_wide;
  logic [6:0]  new_step;
  logic [4:0]  fnum;
  logic [31:0] fbit;
  logic [15:0] gap;
  lac_out_t    res;

  assign src_is_owner = (item_i.source_node == owner_q);
  assign owned_by_src = !is_free_q && src_is_owner;

  // Step = pct * 126 / 100 + 1, saturated; the divide is a reciprocal multiply.
  assign pct_x126  = {item_i.arg_b, 7'd0} - {6'd0, item_i.arg_b, 1'b0};
  assign prod      = 28'(pct_x126) * 28'(RECIP_100);
  assign step_wide = 10'(prod[27:RECIP_SHIFT]) + 10'd1;
  assign new_step  = (step_wide > 10'(SPEED_MAX)) ? SPEED_MAX : step_wide[6:0];

  assign fnum = 5'(item_i.arg_a - 8'd1);
  assign fbit = 32'd1 << fnum;
  assign gap  = item_i.now_ms - last_send_q;

  always_comb begin
    is_free_d   = is_free_q;
    owner_d     = owner_q;
    phase_d     = phase_q;
    step_d      = step_q;
    rev_d       = rev_q;
    fbits_d     = fbits_q;
    last_send_d = last_send_q;
    res         = '0;

    case (lac_func_e'(item_i.func))
      FUNC_DATAGRAM: begin
        if (item_i.class_byte == regs_i.motive_class_code) begin
          if (item_i.command_byte == regs_i.attach_code) begin
            res.handled     = 1'b1;
            res.reply_valid = 1'b1;
            res.reply_dest  = item_i.source_node;
            if (is_free_q || src_is_owner) begin
              is_free_d      = 1'b0;
              owner_d        = item_i.source_node;
              phase_d        = PHASE_ATTACHING;
              res.reply_kind = REPLY_ATTACHED;
            end else begin
              res.reply_kind = REPLY_DENIED;
            end
          end else if (item_i.command_byte == regs_i.release_code) begin
            if (owned_by_src) begin
              res.handled     = 1'b1;
              res.reply_valid = 1'b1;
              res.reply_kind  = REPLY_RELEASED;
              res.reply_dest  = item_i.source_node;
              phase_d         = PHASE_RELEASING;
            end
          end else if (item_i.command_byte == regs_i.set_speed_code) begin
            if (owned_by_src) begin
              step_d              = new_step;
              rev_d               = (item_i.arg_a != 8'd1);
              res.handled         = 1'b1;
              res.speed_cmd_valid = 1'b1;
              res.signed_speed    = lac_signed_speed(new_step, item_i.arg_a != 8'd1);
            end
          end else if (item_i.command_byte == regs_i.set_function_code) begin
            if (owned_by_src) begin
              // Function numbers outside 1..32 leave the bits alone.
              if (item_i.arg_a != 8'd0 && item_i.arg_a <= FUNC_NUM_MAX) begin
                fbits_d = (item_i.arg_b != 8'd0) ? (fbits_q | fbit) : (fbits_q & ~fbit);
              end
              res.handled            = 1'b1;
              res.function_cmd_valid = 1'b1;
            end
          end
        end
      end
      FUNC_RESULT: begin
        // A nak on attach or any result on release tears the link down.
        if ((phase_q == PHASE_ATTACHING && !item_i.accepted) ||
            phase_q == PHASE_RELEASING) begin
          is_free_d           = 1'b1;
          phase_d             = PHASE_IDLE;
          owner_d             = '0;
          step_d              = '0;
          rev_d               = 1'b0;
          res.detached        = 1'b1;
          res.speed_cmd_valid = 1'b1;
          res.speed_cmd_basic = 1'b1;
          res.signed_speed    = 8'sd1;
        end else if (phase_q == PHASE_ATTACHING) begin
          phase_d = PHASE_IDLE;
        end
      end
      FUNC_TICK: begin
        if (gap > regs_i.keepalive_ms) begin
          last_send_d         = item_i.now_ms;
          res.speed_cmd_valid = 1'b1;
          res.signed_speed    = lac_signed_speed(step_q, rev_q);
        end
      end
      default: ;
    endcase

    res.function_mask = fbits_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_free_q   <= 1'b1;
      owner_q     <= '0;
      phase_q     <= PHASE_IDLE;
      step_q      <= '0;
      rev_q       <= 1'b0;
      fbits_q     <= '0;
      last_send_q <= '0;
    end else if (advance_i) begin
      is_free_q   <= is_free_d;
      owner_q     <= owner_d;
      phase_q     <= phase_d;
      step_q      <= step_d;
      rev_q       <= rev_d;
      fbits_q     <= fbits_d;
      last_send_q <= last_send_d;
    end
  end

  assign result_o = res;

`ifndef NO_ASSERTIONS
  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PHASE_IDLE || phase_q == PHASE_ATTACHING || phase_q == PHASE_RELEASING)
    else $error("link phase holds the unused code");
  a_free_is_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_free_q |-> (phase_q == PHASE_IDLE && owner_q == '0))
    else $error("free locomotive has a pending link phase or an owner");
  a_free_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_free_q |-> (step_q == '0 && !rev_q))
    else $error("free locomotive keeps a speed or direction");
`endif

endmodule

FILE: hdl/locomotive_attach_control.sv
`timescale 1ns / 1ps

// Locomotive owner-link controller.
// in_i carries one item per handshake: a received datagram, the outcome of a
// datagram we sent, or a millisecond tick. out_o returns exactly one result
// item for each input item, in order. cfg_i writes one configuration register
// per handshake (addresses 0..6, others ignored) and is always ready; write it
// only while no item is in flight.
// An accepted item is captured in the input register; its result is then
// loaded into the output register that drives out_o. Throughput is one item
// per cycle while out_o is not stalled: the input register feeds the decode
// and state-update logic, which loads the output register in the same cycle
// it updates link state. When the receiver stalls, the output register holds
// its result and the input register can still take one more item; in_i.ready
// then drops until out_o drains.
// Reset clears both pipeline stages, returns the locomotive to free with no
// owner, speed zero, forward and all functions off, and loads the default
// register values (keepalive 5000 ms, command codes 1 to 4).
module locomotive_attach_control
  import lac_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  lac_stream_if.sink   in_i,
  lac_stream_if.source out_o,
  lac_stream_if.sink   cfg_i
);

  lac_regs_t regs;
  lac_in_t   item_q;
  logic      s1_valid_q;
  lac_out_t  result;
  lac_out_t  out_q;
  logic      out_valid_q;
  logic      advance;
  logic      in_fire;

  assign cfg_i.ready = 1'b1;

  lac_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (cfg_i.valid),
    .wr_i    (cfg_i.data),
    .regs_o  (regs)
  );

  assign advance     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || advance;
  assign in_fire     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_i.data;
    end
  end

  lac_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (item_q),
    .regs_i    (regs),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

`ifndef NO_ASSERTIONS
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_valid_q)
    else $error("accepted item not held in the input register");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(item_q))
    else $error("stalled item lost from the input register");
  a_reply_handled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.reply_valid |-> out_q.handled)
    else $error("reply without a handled datagram");
  a_detach_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.detached |->
      out_q.speed_cmd_valid && out_q.speed_cmd_basic && !out_q.handled)
    else $error("detach without the basic stop command");
  a_func_handled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.function_cmd_valid |-> out_q.handled && !out_q.speed_cmd_valid)
    else $error("function command outside a handled datagram");
`endif

endmodule
